// ===== hw/rtl/lbf_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink/fade controller package
// Shared mode codes, pin write kinds and input command codes.
// ----------------------------------------------------------------------------
package lbf_pkg;

  // LED modes as reported on active_mode_o and pending_mode_o.
  localparam logic [3:0] M_OFF         = 4'd0;
  localparam logic [3:0] M_ON          = 4'd1;
  localparam logic [3:0] M_ON_DIM      = 4'd2;
  localparam logic [3:0] M_BLINK       = 4'd3;
  localparam logic [3:0] M_DIM_BLINK   = 4'd4;
  localparam logic [3:0] M_FADE_ON     = 4'd5;
  localparam logic [3:0] M_FADE_ON_DIM = 4'd6;
  localparam logic [3:0] M_FADE_OFF    = 4'd7;
  localparam logic [3:0] M_PULSE       = 4'd8;

  // Input command codes.
  localparam logic [3:0] C_TICK        = 4'd0;
  localparam logic [3:0] C_ON          = 4'd1;
  localparam logic [3:0] C_OFF         = 4'd2;
  localparam logic [3:0] C_ON_DIM      = 4'd3;
  localparam logic [3:0] C_BLINK       = 4'd4;
  localparam logic [3:0] C_DIM_BLINK   = 4'd5;
  localparam logic [3:0] C_FADE_ON     = 4'd6;
  localparam logic [3:0] C_FADE_ON_DIM = 4'd7;
  localparam logic [3:0] C_FADE_OFF    = 4'd8;
  localparam logic [3:0] C_PULSE       = 4'd9;

  // Pin write kinds.
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_DIG  = 2'd1;
  localparam logic [1:0] WK_PWM  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_OFF_POL = 1'b0;
  localparam logic REG_MAX_LVL = 1'b1;

  // Divider handshake.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== hw/rtl/led_blink_fade_controller.sv =====
// ----------------------------------------------------------------------------
// LED blink/fade controller
// Schedules LED modes and reports the pin write for every millisecond tick.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries commands and ticks.
// A mode code of zero is a tick that advances the millisecond counter and runs
// the blink and fade services; other codes schedule a new mode. Every beat
// yields exactly one result beat on the output channel (out_valid_o/out_ready_i)
// reporting the pin write and the current and pending modes.
// Path from acceptance to out_valid_o: a command passes through S_CMD, a
// tick outside the fade modes through S_BASE and S_FADE, and a fading tick
// through S_BASE, S_FADE and S_DIV; with a zero ramp interval S_DIV gives
// the end level without dividing. A ramping tick waits in S_DIV for the
// serial ramp divider, which produces one quotient bit per cycle. One item
// is processed at a time: in_ready_o returns in the cycle after the result
// beat is taken, and while the receiver stalls the result is held and the
// block waits.
// Reset clears the counter and modes to off, levels to zero and 255 (the
// reset max level), intervals to DEFAULT_MS. Configuration writes (off
// polarity, max level) take effect at once and are meant to happen only while idle.
// ----------------------------------------------------------------------------
module led_blink_fade_controller #(
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16,
  parameter int DEFAULT_MS = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [15:0] level_a_i,
  input  logic [15:0] level_b_i,
  input  logic [15:0] time_on_i,
  input  logic [15:0] time_off_i,
  input  logic [15:0] start_delay_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  write_kind_o,
  output logic        pin_bit_o,
  output logic [15:0] pwm_level_o,
  output logic [3:0]  active_mode_o,
  output logic [3:0]  pending_mode_o
);
  import lbf_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int LB = LEVEL_BITS;
  localparam int NB = 16 + LB; // elapsed times span product width

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMD   = 6'b000010,
    S_BASE  = 6'b000100,
    S_FADE  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic          off_pol_q;
  logic [LB-1:0] max_q;

  // Controller state.
  logic [TB-1:0] now_q, sw_q, ph_q;
  logic [3:0]    cur_q, req_q;
  logic          bph_q, up_q;
  logic [LB-1:0] lo_q, hi_q, tgt_q;
  logic [15:0]   ton_q, toff_q;

  // Captured item and result.
  logic [3:0]    md_q;
  logic [LB-1:0] la_q, lb_q;
  logic [15:0]   tn_q, tf_q, dl_q;
  logic [1:0]    wk_q;
  logic          wb_q;
  logic [15:0]   wp_q;

  // Divider operands and ramp sequencing.
  logic [NB-1:0] div_quot;
  div_ctl_t      div_ctl;
  logic [NB-1:0] num_q;
  logic [15:0]   den_q;
  logic          go_q, kick_q;
  logic [TB-1:0] el_r, iv_r;
  logic          zero_iv;

  lbf_divider #(.NUM_BITS(NB), .DEN_BITS(16)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .ctl_o   (div_ctl),
    .quot_o  (div_quot)
  );

  function automatic logic fading(input logic [3:0] m);
    return (m == M_FADE_ON) || (m == M_FADE_ON_DIM) || (m == M_FADE_OFF) ||
           (m == M_PULSE);
  endfunction

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_pol_q <= 1'b0;
      max_q     <= LB'(255);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_OFF_POL) off_pol_q <= cfg_data_i[0];
      else                            max_q     <= cfg_data_i[LB-1:0];
    end
  end

  // Next-state values of the controller.
  logic [TB-1:0] now_d, sw_d, ph_d;
  logic [3:0]    cur_d, req_d;
  logic          bph_d, up_d;
  logic [LB-1:0] lo_d, hi_d, tgt_d;
  logic [15:0]   ton_d, toff_d;
  logic [1:0]    wk_d;
  logic          wb_d;
  logic [15:0]   wp_d;
  logic          ramp_go;

  // Helper values used in the combinational sequencer.
  logic          keeps;
  logic [TB-1:0] sched, lim;
  logic [LB-1:0] inv_a, fa, fb, hi_t, lo_t, ft;
  logic [LB:0]   span;
  logic          neg;
  logic [LB-1:0] amag;
  logic [LB-1:0] ramp_sum;

  assign keeps = (cur_q == M_PULSE) || (cur_q == M_DIM_BLINK) || (cur_q == M_ON_DIM);
  assign sched = now_q + TB'(dl_q);
  assign inv_a = max_q - la_q;

  // Ordered levels for dim blink and pulse.
  always_comb begin
    if ((la_q < lb_q && !off_pol_q) || (la_q > lb_q && off_pol_q)) begin
      fa = la_q;
      fb = lb_q;
    end else begin
      fa = lb_q;
      fb = la_q;
    end
  end

  assign span = {1'b0, hi_q} - {1'b0, lo_q};
  assign neg  = span[LB];
  assign amag = neg ? LB'(-span) : span[LB-1:0];
  assign ramp_sum = neg ? (lo_q - div_quot[LB-1:0]) : (lo_q + div_quot[LB-1:0]);

  // Ramp operands, computed from the registered state once S_FADE commits.
  always_comb begin
    iv_r = up_q ? TB'(ton_q) : TB'(toff_q);
    el_r = up_q ? (now_q - (ph_q - iv_r)) : (ph_q - now_q);
    if (el_r > iv_r) el_r = iv_r;
    zero_iv = (iv_r == '0);
  end

  always_comb begin
    state_d = state_q;
    now_d = now_q; sw_d = sw_q; ph_d = ph_q;
    cur_d = cur_q; req_d = req_q; bph_d = bph_q; up_d = up_q;
    lo_d = lo_q; hi_d = hi_q; tgt_d = tgt_q; ton_d = ton_q; toff_d = toff_q;
    wk_d = wk_q; wb_d = wb_q; wp_d = wp_q;
    ramp_go = 1'b0;
    lim = '0; hi_t = '0; lo_t = '0; ft = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          wk_d = WK_NONE; wb_d = 1'b0; wp_d = '0;
          state_d = (mode_i == C_TICK) ? S_BASE : S_CMD;
          if (mode_i == C_TICK) now_d = now_q + TB'(1);
        end
      end
      S_CMD: begin
        state_d = S_OUT;
        case (md_q)
          C_ON: begin
            sw_d = sched; req_d = M_ON;
          end
          C_OFF: begin
            sw_d = sched; req_d = M_OFF;
          end
          C_ON_DIM: begin
            sw_d = sched; req_d = M_ON_DIM;
            hi_d = off_pol_q ? inv_a : la_q; lo_d = hi_d;
          end
          C_BLINK: begin
            sw_d = sched; req_d = M_BLINK;
            ton_d = off_pol_q ? tf_q : tn_q; toff_d = off_pol_q ? tn_q : tf_q;
          end
          C_DIM_BLINK, C_PULSE: begin
            sw_d = sched;
            ton_d = off_pol_q ? tf_q : tn_q; toff_d = off_pol_q ? tn_q : tf_q;
            lo_d = off_pol_q ? LB'(max_q - fa) : fa;
            hi_d = off_pol_q ? LB'(max_q - fb) : fb;
            req_d = (md_q == C_PULSE) ? M_PULSE : M_DIM_BLINK;
            if (md_q == C_PULSE && hi_d > max_q) hi_d = max_q;
          end
          C_FADE_ON: begin
            sw_d = sched;
            if (!keeps) begin
              ton_d = tn_q; lo_d = '0; hi_d = max_q;
            end
            if (cur_q != M_ON) req_d = M_FADE_ON;
          end
          C_FADE_ON_DIM, C_FADE_OFF: begin
            sw_d = sched;
            if (md_q == C_FADE_OFF || la_q == '0) begin
              if (!keeps) begin
                toff_d = tn_q; lo_d = '0; hi_d = max_q;
              end
              if (cur_q != M_OFF) req_d = M_FADE_OFF;
            end else begin
              ft = off_pol_q ? inv_a : la_q;
              tgt_d = ft;
              if (!keeps) begin
                ton_d = tn_q;
                lo_d = off_pol_q ? ft : '0;
                hi_d = off_pol_q ? max_q : ft;
              end
              if (cur_q != M_ON && cur_q != M_ON_DIM) req_d = M_FADE_ON_DIM;
            end
          end
          default: ;
        endcase
      end
      S_BASE: begin
        state_d = S_FADE;
        if (cur_q != req_q && sw_q <= now_q) begin
          case (req_q)
            M_OFF: begin
              wk_d = WK_DIG; wb_d = off_pol_q; cur_d = req_q;
            end
            M_ON: begin
              wk_d = WK_DIG; wb_d = !off_pol_q; cur_d = req_q;
            end
            M_BLINK, M_DIM_BLINK: begin
              bph_d = (cur_q == M_OFF) ? off_pol_q : !off_pol_q;
              ph_d = '0; cur_d = req_q;
            end
            M_ON_DIM: begin
              wk_d = WK_PWM; wp_d = 16'(off_pol_q ? lo_q : hi_q); cur_d = req_q;
            end
            default: ;
          endcase
        end
        if (cur_d == M_BLINK || cur_d == M_DIM_BLINK) begin
          lim = ph_d + TB'(bph_d ? ton_q : toff_q);
          if (now_q > lim) begin
            ph_d = now_q; bph_d = !bph_d;
            if (cur_d == M_BLINK) begin
              wk_d = WK_DIG; wb_d = bph_d; wp_d = '0;
            end else begin
              wk_d = WK_PWM; wb_d = 1'b0; wp_d = 16'(bph_d ? hi_q : lo_q);
            end
          end
        end
      end
      S_FADE: begin
        state_d = S_OUT;
        if (cur_q != req_q && sw_q <= now_q) begin
          if (fading(req_q) && !fading(cur_q)) begin
            ph_d = '0;
            up_d = (req_q == M_FADE_OFF || cur_q == M_ON || cur_q == M_ON_DIM) ?
                   !off_pol_q : off_pol_q;
          end
          cur_d = req_q;
        end
        if (fading(cur_d)) begin
          if (now_q > ph_d) begin
            up_d = !up_d;
            ph_d = now_q + TB'(up_d ? ton_q : toff_q);
            if (cur_d == M_FADE_ON || cur_d == M_FADE_ON_DIM) begin
              hi_t = (cur_d == M_FADE_ON_DIM) ? tgt_q : max_q;
              lo_t = (cur_d == M_FADE_ON_DIM) ? tgt_q : '0;
              if (up_d == !off_pol_q) begin
                if (!off_pol_q) hi_d = hi_t; else lo_d = lo_t;
              end else if (!off_pol_q) begin
                if (hi_q == hi_t) req_d = (cur_d == M_FADE_ON_DIM) ? M_ON_DIM : M_ON;
              end else if (lo_q == lo_t) begin
                req_d = (cur_d == M_FADE_ON_DIM) ? M_ON_DIM : M_ON;
              end
            end
            if (cur_d == M_FADE_OFF) begin
              if (up_d == off_pol_q) begin
                if (!off_pol_q) lo_d = '0; else hi_d = max_q;
              end else if (!off_pol_q) begin
                if (lo_q == '0) req_d = M_OFF;
              end else if (hi_q == max_q) begin
                req_d = M_OFF;
              end
            end
          end
          // Ramp set-up; the levels are read after this tick's updates.
          state_d = S_DIV;
          wk_d = WK_PWM; wb_d = 1'b0;
          ramp_go = 1'b1;
        end
      end
      S_DIV: begin
        // A zero interval gives the end level without dividing.
        if (go_q && zero_iv) begin
          wp_d = 16'(up_q ? hi_q : lo_q);
          state_d = S_OUT;
        end else if (div_ctl.done) begin
          wp_d = 16'(ramp_sum);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer and controller state. The product is latched in the first
  // divide cycle and the divider is kicked in the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q <= 1'b0;
      kick_q <= 1'b0;
      now_q <= '0; sw_q <= '0; ph_q <= '0;
      cur_q <= M_OFF; req_q <= M_OFF; bph_q <= 1'b0; up_q <= 1'b0;
      lo_q <= '0; hi_q <= LB'(255); tgt_q <= '0;
      ton_q <= 16'(DEFAULT_MS); toff_q <= 16'(DEFAULT_MS);
      wk_q <= WK_NONE; wb_q <= 1'b0; wp_q <= '0;
    end else begin
      state_q <= state_d;
      go_q <= ramp_go;
      kick_q <= go_q && !zero_iv;
      now_q <= now_d; sw_q <= sw_d; ph_q <= ph_d;
      cur_q <= cur_d; req_q <= req_d; bph_q <= bph_d; up_q <= up_d;
      lo_q <= lo_d; hi_q <= hi_d; tgt_q <= tgt_d;
      ton_q <= ton_d; toff_q <= toff_d;
      wk_q <= wk_d; wb_q <= wb_d; wp_q <= wp_d;
    end
  end

  // Item capture and the registered product; elapsed time is at most the
  // 16-bit interval after saturation.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      md_q <= mode_i;
      la_q <= level_a_i[LB-1:0]; lb_q <= level_b_i[LB-1:0];
      tn_q <= time_on_i; tf_q <= time_off_i; dl_q <= start_delay_i;
    end
    if (go_q) begin
      num_q <= NB'(el_r[15:0]) * NB'(amag);
      den_q <= iv_r[15:0];
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign write_kind_o   = wk_q;
  assign pin_bit_o      = wb_q;
  assign pwm_level_o    = wp_q;
  assign active_mode_o  = cur_q;
  assign pending_mode_o = req_q;

endmodule

// ===== hw/rtl/lbf_divider.sv =====
// ----------------------------------------------------------------------------
// LED blink/fade ramp divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbf_divider #(
  parameter int NUM_BITS = 32,
  parameter int DEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  output lbf_pkg::div_ctl_t   ctl_o,
  output logic [NUM_BITS-1:0] quot_o
);
  import lbf_pkg::*;

  localparam int CntBits = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quot_q, quot_d;
  logic [DEN_BITS:0]   rem_q, rem_d;
  logic [DEN_BITS-1:0] den_q, den_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [DEN_BITS:0]   trial;

  // One restoring step per cycle, quotient shifted in from the right.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DEN_BITS-1:0], quot_q[NUM_BITS-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NUM_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NUM_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign quot_o      = quot_q;

endmodule
